FILE: rtl/cache_range_maintenance_sequencer_unit_macros.svh
// Assertion macros shared by the sequencer checker
`ifndef CACHE_RANGE_MAINTENANCE_SEQUENCER_UNIT_MACROS_SVH
`define CACHE_RANGE_MAINTENANCE_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define CRMS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crms assertion failed");

// next-cycle implication, off while in reset
`define CRMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crms assertion failed");

// state right after a reset cycle
`define CRMS_ASSERT_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("crms reset assertion failed");

`endif

FILE: rtl/crms_pkg.sv
// Package: constants, codes and types of the cache range maintenance sequencer
`timescale 1ns / 1ps
package crms_pkg;

  localparam logic [31:0] LINE_BYTES = 32'd32;
  localparam logic [31:0] LINE_MASK  = LINE_BYTES - 32'd1;

  localparam logic [7:0]  WAY_MASK_RESET   = 8'hFF;
  localparam logic [31:0] CACHE_SIZE_RESET = 32'd131072;

  localparam logic CFG_WAY_MASK   = 1'b0;
  localparam logic CFG_CACHE_SIZE = 1'b1;

  localparam logic [2:0] OP_STEP      = 3'd0;
  localparam logic [2:0] OP_INV_RANGE = 3'd1;
  localparam logic [2:0] OP_CLN_RANGE = 3'd2;
  localparam logic [2:0] OP_CI_RANGE  = 3'd3;
  localparam logic [2:0] OP_CLN_ALL   = 3'd4;
  localparam logic [2:0] OP_INV_ALL   = 3'd5;
  localparam logic [2:0] OP_CI_ALL    = 3'd6;

  localparam logic [2:0] K_CLEAN_LINE = 3'd0;
  localparam logic [2:0] K_INV_LINE   = 3'd1;
  localparam logic [2:0] K_CI_LINE    = 3'd2;
  localparam logic [2:0] K_CLEAN_WAYS = 3'd3;
  localparam logic [2:0] K_INV_WAYS   = 3'd4;
  localparam logic [2:0] K_CI_WAYS    = 3'd5;
  localparam logic [2:0] K_SYNC       = 3'd6;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TAIL  = 3'd1;
  localparam logic [2:0] PH_LINES = 3'd2;
  localparam logic [2:0] PH_WAIT  = 3'd3;
  localparam logic [2:0] PH_SYNC  = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [7:0]  way_busy;
  } req_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [31:0] data;
    logic        last;
  } cmd_t;

endpackage

FILE: rtl/crms_seq.sv
// Sequencer state and per-item command selection
`timescale 1ns / 1ps
module crms_seq import crms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  req_t        req,
  input  logic [7:0]  way_mask,
  input  logic [31:0] cache_size,
  output cmd_t        res
);

  logic [2:0]  phase, phase_next;
  logic [2:0]  op_kind, op_kind_next;
  logic [31:0] cur_line, cur_line_next;
  logic [31:0] stop_addr, stop_addr_next;
  logic [31:0] tail_line, tail_line_next;

  logic        do_adv;
  logic [2:0]  p;
  logic [2:0]  k;
  logic [31:0] c;
  logic [31:0] st;
  logic [31:0] tl;
  logic [31:0] head;
  logic [31:0] head_next;
  logic [31:0] len;
  logic        has_tail;
  logic [32:0] nxt;

  always_comb begin
    phase_next     = phase;
    op_kind_next   = op_kind;
    cur_line_next  = cur_line;
    stop_addr_next = stop_addr;
    tail_line_next = tail_line;
    res            = '0;
    do_adv         = 1'b0;
    p              = phase;
    k              = op_kind;
    c              = cur_line;
    st             = stop_addr;
    tl             = tail_line;
    has_tail       = (req.end_addr & LINE_MASK) != 32'd0;
    head           = req.start_addr & ~LINE_MASK;
    head_next      = head + LINE_BYTES;
    len            = req.end_addr - req.start_addr;
    nxt            = '0;

    if (phase != PH_IDLE) begin
      do_adv = 1'b1;
    end else if (req.opcode inside {[OP_INV_RANGE:OP_CI_ALL]}) begin
      k            = req.opcode;
      op_kind_next = req.opcode;
      case (req.opcode)
        OP_INV_RANGE: begin
          st             = req.end_addr & ~LINE_MASK;
          tl             = st;
          stop_addr_next = st;
          tail_line_next = st;
          if ((req.start_addr & LINE_MASK) != 32'd0) begin
            cur_line_next = head_next;
            if (has_tail) begin
              phase_next = PH_TAIL;
            end else begin
              phase_next = (head_next < st) ? PH_LINES : PH_SYNC;
            end
            res = '{valid: 1'b1, kind: K_CI_LINE, data: head, last: 1'b0};
          end else begin
            c      = req.start_addr;
            p      = has_tail ? PH_TAIL : ((req.start_addr < st) ? PH_LINES : PH_SYNC);
            do_adv = 1'b1;
          end
        end
        OP_CLN_RANGE, OP_CI_RANGE: begin
          if (len >= cache_size) begin
            phase_next = PH_WAIT;
            res = '{valid: 1'b1,
                    kind: (req.opcode == OP_CLN_RANGE) ? K_CLEAN_WAYS : K_CI_WAYS,
                    data: {24'd0, way_mask}, last: 1'b0};
          end else begin
            c      = head;
            st     = req.end_addr;
            p      = (head < req.end_addr) ? PH_LINES : PH_SYNC;
            do_adv = 1'b1;
          end
        end
        OP_CLN_ALL: begin
          phase_next = PH_WAIT;
          res = '{valid: 1'b1, kind: K_CLEAN_WAYS, data: {24'd0, way_mask}, last: 1'b0};
        end
        OP_INV_ALL: begin
          phase_next = PH_WAIT;
          res = '{valid: 1'b1, kind: K_INV_WAYS, data: {24'd0, way_mask}, last: 1'b0};
        end
        default: begin
          phase_next = PH_WAIT;
          res = '{valid: 1'b1, kind: K_CI_WAYS, data: {24'd0, way_mask}, last: 1'b0};
        end
      endcase
    end

    if (do_adv) begin
      cur_line_next  = c;
      stop_addr_next = st;
      tail_line_next = tl;
      nxt            = {1'b0, c} + {1'b0, LINE_BYTES};
      case (p)
        PH_TAIL: begin
          phase_next = (c < st) ? PH_LINES : PH_SYNC;
          res = '{valid: 1'b1, kind: K_CI_LINE, data: tl, last: 1'b0};
        end
        PH_LINES: begin
          if (nxt[32] || (nxt[31:0] >= st)) begin
            phase_next = PH_SYNC;
          end else begin
            phase_next    = PH_LINES;
            cur_line_next = nxt[31:0];
          end
          res.valid = 1'b1;
          res.kind  = (k == OP_CLN_RANGE) ? K_CLEAN_LINE :
                      (k == OP_CI_RANGE)  ? K_CI_LINE : K_INV_LINE;
          res.data  = c;
          res.last  = 1'b0;
        end
        PH_WAIT: begin
          if (req.way_busy == 8'd0) begin
            phase_next = PH_IDLE;
            res = '{valid: 1'b1, kind: K_SYNC, data: 32'd0, last: 1'b1};
          end else begin
            phase_next = PH_WAIT;
          end
        end
        PH_SYNC: begin
          phase_next = PH_IDLE;
          res = '{valid: 1'b1, kind: K_SYNC, data: 32'd0, last: 1'b1};
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      op_kind <= OP_STEP;
    end else if (fire) begin
      phase   <= phase_next;
      op_kind <= op_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_line  <= 32'd0;
      stop_addr <= 32'd0;
      tail_line <= 32'd0;
    end else if (fire) begin
      cur_line  <= cur_line_next;
      stop_addr <= stop_addr_next;
      tail_line <= tail_line_next;
    end
  end

endmodule

FILE: rtl/cache_range_maintenance_sequencer_unit.sv
// Top level: handshakes, configuration registers and result register
//
// Input channel (in_valid / in_stall) carries one item: opcode, start_addr,
// end_addr and way_busy. A request opcode is taken only while no operation
// runs; otherwise the item acts as a step. Every item yields zero or one
// controller command on the output channel (out_valid / out_stall) as
// cmd_valid, cmd_kind, cmd_data and last; last marks the closing sync.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
// way_mask (index 0) and cache_size (index 1); cfg_ready is always high
// and writes are expected only while the block is idle.
// An accepted item is held in the input register, and its command is then
// registered in the result register. Throughput is one item per cycle while
// the receiver does not stall, set by the single input register feeding the
// result register. When the receiver stalls, the result holds and the input
// register fills, then in_stall rises until the result is taken.
// Reset clears both stages, the sequencer phase, and restores way_mask to
// 0xFF and cache_size to 131072.
`timescale 1ns / 1ps
module cache_range_maintenance_sequencer_unit import crms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [31:0] start_addr,
  input  logic [31:0] end_addr,
  input  logic [7:0]  way_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        cmd_valid,
  output logic [2:0]  cmd_kind,
  output logic [31:0] cmd_data,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [7:0]  way_mask;
  logic [31:0] cache_size;
  logic        s1_valid;
  req_t        s1_req;
  logic        s1_fire;
  cmd_t        res;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      way_mask   <= WAY_MASK_RESET;
      cache_size <= CACHE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WAY_MASK:   way_mask   <= cfg_data[7:0];
        CFG_CACHE_SIZE: cache_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req <= '{opcode: opcode, start_addr: start_addr,
                  end_addr: end_addr, way_busy: way_busy};
    end
  end

  crms_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_fire),
    .req        (s1_req),
    .way_mask   (way_mask),
    .cache_size (cache_size),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= res.valid;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      cmd_valid <= res.valid;
      cmd_kind  <= res.kind;
      cmd_data  <= res.data;
      last      <= res.last;
    end
  end

endmodule

FILE: rtl/crms_checker.sv
// Port-level checker for the sequencer, bound to the top level
`timescale 1ns / 1ps
`include "cache_range_maintenance_sequencer_unit_macros.svh"
module crms_checker import crms_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        cmd_valid,
  input logic [2:0]  cmd_kind,
  input logic [31:0] cmd_data,
  input logic        last
);

  logic ways_cmd;

  assign ways_cmd = cmd_kind inside {K_CLEAN_WAYS, K_INV_WAYS, K_CI_WAYS};

  `CRMS_ASSERT_NOW(a_last_is_sync, clk, rst, out_valid && last, (cmd_kind == K_SYNC) && (cmd_data == 32'd0))
  `CRMS_ASSERT_NOW(a_sync_is_last, clk, rst, out_valid && (cmd_kind == K_SYNC), last && cmd_valid)
  `CRMS_ASSERT_NOW(a_ways_mask_width, clk, rst, out_valid && ways_cmd, cmd_data[31:8] == 24'd0)
  `CRMS_ASSERT_RESET(a_reset_empty, clk, rst, !out_valid && !in_stall)
  `CRMS_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && out_stall, out_valid && $stable(cmd_data) && $stable(cmd_kind))

endmodule

bind cache_range_maintenance_sequencer_unit crms_checker u_crms_checker (.*);

FILE: tb/tb_top.sv
// Testbench for the cache range maintenance sequencer: drives requests, predicts and checks commands
`timescale 1ns / 1ps
import crms_pkg::*;

localparam logic [2:0] OP_NOP = 3'd7;

class maint_cmd_tracker;
  logic [7:0]  way_mask;
  logic [31:0] cache_size;
  logic [2:0]  phase;
  logic [2:0]  op_kind;
  logic [31:0] cur_line;
  logic [31:0] stop_addr;
  logic [31:0] tail_line;
  cmd_t        due_cmds[$];
  int unsigned fails;

  function new();
    way_mask   = WAY_MASK_RESET;
    cache_size = CACHE_SIZE_RESET;
    phase      = PH_IDLE;
    op_kind    = 3'd0;
    cur_line   = 32'd0;
    stop_addr  = 32'd0;
    tail_line  = 32'd0;
    fails      = 0;
  endfunction

  function void set_reg(logic idx, logic [31:0] val);
    if (idx == CFG_WAY_MASK) way_mask = val[7:0];
    else cache_size = val;
  endfunction

  function cmd_t make_cmd(logic [2:0] kind, logic [31:0] data, logic fin);
    cmd_t c;
    c.valid = 1'b1;
    c.kind  = kind;
    c.data  = data;
    c.last  = fin;
    return c;
  endfunction

  function logic [2:0] walk_entry();
    return (cur_line < stop_addr) ? PH_LINES : PH_SYNC;
  endfunction

  // advance a running operation by one item
  function bit step_walk(logic [7:0] busy, output cmd_t c);
    logic [31:0] ln;
    logic [31:0] nx;
    step_walk = 1'b1;
    c = '0;
    case (phase)
      PH_TAIL: begin
        phase = walk_entry();
        c = make_cmd(K_CI_LINE, tail_line, 1'b0);
      end
      PH_LINES: begin
        ln = cur_line;
        nx = ln + LINE_BYTES;
        if (nx < ln || nx >= stop_addr) phase = PH_SYNC;
        else cur_line = nx;
        c = make_cmd(op_kind == OP_CLN_RANGE ? K_CLEAN_LINE :
                     op_kind == OP_CI_RANGE ? K_CI_LINE : K_INV_LINE, ln, 1'b0);
      end
      PH_WAIT: begin
        if (busy != 8'd0) begin
          step_walk = 1'b0;
        end else begin
          phase = PH_IDLE;
          c = make_cmd(K_SYNC, 32'd0, 1'b1);
        end
      end
      PH_SYNC: begin
        phase = PH_IDLE;
        c = make_cmd(K_SYNC, 32'd0, 1'b1);
      end
      default: begin
        phase = PH_IDLE;
        step_walk = 1'b0;
      end
    endcase
  endfunction

  function void accept_item(logic [2:0] opc, logic [31:0] s, logic [31:0] e, logic [7:0] busy);
    cmd_t        c;
    bit          hit;
    logic [31:0] span;
    hit = 1'b0;
    c = '0;
    span = e - s;
    if (phase != PH_IDLE) begin
      hit = step_walk(busy, c);
    end else if (opc != OP_STEP && opc != OP_NOP) begin
      op_kind = opc;
      case (opc)
        OP_INV_RANGE: begin
          stop_addr = e & ~LINE_MASK;
          tail_line = stop_addr;
          if ((s & LINE_MASK) != 32'd0) begin
            cur_line = (s & ~LINE_MASK) + LINE_BYTES;
            phase = ((e & LINE_MASK) != 32'd0) ? PH_TAIL : walk_entry();
            c = make_cmd(K_CI_LINE, s & ~LINE_MASK, 1'b0);
            hit = 1'b1;
          end else begin
            cur_line = s;
            phase = ((e & LINE_MASK) != 32'd0) ? PH_TAIL : walk_entry();
            hit = step_walk(busy, c);
          end
        end
        OP_CLN_RANGE, OP_CI_RANGE: begin
          if (span >= cache_size) begin
            phase = PH_WAIT;
            c = make_cmd(opc == OP_CLN_RANGE ? K_CLEAN_WAYS : K_CI_WAYS, {24'd0, way_mask}, 1'b0);
            hit = 1'b1;
          end else begin
            cur_line = s & ~LINE_MASK;
            stop_addr = e;
            phase = walk_entry();
            hit = step_walk(busy, c);
          end
        end
        default: begin
          phase = PH_WAIT;
          c = make_cmd(opc == OP_CLN_ALL ? K_CLEAN_WAYS :
                       opc == OP_INV_ALL ? K_INV_WAYS : K_CI_WAYS, {24'd0, way_mask}, 1'b0);
          hit = 1'b1;
        end
      endcase
    end
    if (hit) due_cmds.push_back(c);
  endfunction

  function void match_cmd(cmd_t got);
    cmd_t want;
    if (due_cmds.size() == 0) begin
      $display("%0t: command with none expected: kind %0d data %h last %0b",
               $time, got.kind, got.data, got.last);
      fails++;
    end else begin
      want = due_cmds.pop_front();
      if (got.valid !== want.valid) begin
        $display("%0t: cmd_valid expected %0b got %0b", $time, want.valid, got.valid);
        fails++;
      end
      if (got.kind !== want.kind) begin
        $display("%0t: cmd_kind expected %0d got %0d", $time, want.kind, got.kind);
        fails++;
      end
      if (got.data !== want.data) begin
        $display("%0t: cmd_data expected %h got %h", $time, want.data, got.data);
        fails++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
        fails++;
      end
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 260;

  typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_pattern_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  opcode;
  logic [31:0] start_addr;
  logic [31:0] end_addr;
  logic [7:0]  way_busy;
  logic        out_valid;
  logic        out_stall;
  logic        cmd_valid;
  logic [2:0]  cmd_kind;
  logic [31:0] cmd_data;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  maint_cmd_tracker model;
  cmd_t             seen;
  int unsigned      cycles = 0;
  int unsigned      burst_left = 0;
  int unsigned      work_items;
  bit               hold_go = 1'b0;
  bit               hold_done = 1'b0;
  int unsigned      hold_left = 0;
  int unsigned      rx_left = 0;
  rx_pattern_e      rx_mode = RX_FLOW;

  cache_range_maintenance_sequencer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .start_addr (start_addr),
    .end_addr   (end_addr),
    .way_busy   (way_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd_valid  (cmd_valid),
    .cmd_kind   (cmd_kind),
    .cmd_data   (cmd_data),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // check taken commands, then pick the next stall value
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {cmd_valid, cmd_kind, cmd_data, last};
        model.match_cmd(seen);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 150;
        out_stall <= 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_pattern_e'($urandom_range(0, 3));
          rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        case (rx_mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= !out_stall;
        endcase
      end
    end
  end

  task automatic send_item(logic [2:0] opc, logic [31:0] s, logic [31:0] e, logic [7:0] busy);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid   <= 1'b1;
    opcode     <= opc;
    start_addr <= s;
    end_addr   <= e;
    way_busy   <= busy;
    do @(posedge clk); while (in_stall);
    model.accept_item(opc, s, e, busy);
  endtask

  // step until the running operation has issued its sync
  task automatic finish_op();
    logic [2:0] opc;
    logic [7:0] busy;
    while (model.phase != PH_IDLE) begin
      opc = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7)) : OP_STEP;
      busy = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      send_item(opc, $urandom, $urandom, busy);
      work_items++;
    end
  endtask

  task automatic do_op(logic [2:0] opc, logic [31:0] s, logic [31:0] e);
    send_item(opc, s, e, 8'($urandom_range(0, 255)));
    work_items++;
    finish_op();
  endtask

  task automatic rand_op();
    logic [2:0]  opc;
    logic [31:0] s;
    logic [31:0] e;
    if ($urandom_range(0, 9) == 0)
      send_item($urandom_range(0, 1) ? OP_STEP : OP_NOP, $urandom, $urandom,
                8'($urandom_range(0, 255)));
    opc = 3'($urandom_range(1, 6));
    case ($urandom_range(0, 3))
      0:       s = $urandom;
      1:       s = $urandom_range(0, 255);
      2:       s = 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: s = $urandom & ~LINE_MASK;
    endcase
    case ($urandom_range(0, 9))
      0:       e = s;
      1: begin
        e = s - $urandom_range(1, 300);
        // a low start would wrap the end to the top and walk nearly every line
        if (e > s) e = s;
      end
      2:       e = $urandom_range(0, 400);
      3:       e = s + $urandom_range(0, 2000);
      default: e = s + $urandom_range(0, 300);
    endcase
    // a partial head in the top line wraps the walk to zero: keep the end low
    if (opc == OP_INV_RANGE && (s | LINE_MASK) == 32'hFFFF_FFFF && (s & LINE_MASK) != 32'd0)
      e = $urandom_range(0, 200);
    do_op(opc, s, e);
  endtask

  task automatic run_phase();
    work_items = 0;
    while (work_items < PHASE_ITEMS) rand_op();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (model.due_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(logic [7:0] wm, logic [31:0] cs);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WAY_MASK;
    cfg_data  <= {24'd0, wm};
    do @(posedge clk); while (!cfg_ready);
    model.set_reg(CFG_WAY_MASK, {24'd0, wm});
    cfg_index <= CFG_CACHE_SIZE;
    cfg_data  <= cs;
    do @(posedge clk); while (!cfg_ready);
    model.set_reg(CFG_CACHE_SIZE, cs);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    model = new();
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    opcode     <= OP_STEP;
    start_addr <= 32'd0;
    end_addr   <= 32'd0;
    way_busy   <= 8'd0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_WAY_MASK;
    cfg_data   <= 32'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    work_items = 0;
    send_item(OP_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_NOP, 32'd0, 32'd0, 8'd0);
    do_op(OP_INV_RANGE, 32'h0000_1004, 32'h0000_1048);
    do_op(OP_INV_RANGE, 32'h0000_2000, 32'h0000_2080);
    do_op(OP_INV_RANGE, 32'h0000_3010, 32'h0000_3018);
    do_op(OP_INV_RANGE, 32'h0000_4000, 32'h0000_4000);
    do_op(OP_INV_RANGE, 32'hFFFF_FFE8, 32'h0000_0040);
    do_op(OP_INV_RANGE, 32'hFFFF_FFC0, 32'hFFFF_FFFF);
    do_op(OP_CLN_RANGE, 32'h0000_5005, 32'h0000_5070);
    do_op(OP_CLN_RANGE, 32'hFFFF_FFC5, 32'hFFFF_FFFF);
    do_op(OP_CLN_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    do_op(OP_CLN_RANGE, 32'd0, 32'd0);
    do_op(OP_CLN_RANGE, 32'h0000_0010, 32'd0);
    do_op(OP_CI_RANGE, 32'h0000_0100, 32'h0000_0100 + CACHE_SIZE_RESET);
    do_op(OP_CI_RANGE, 32'h0000_6003, 32'h0000_6041);
    send_item(OP_CLN_ALL, 32'd0, 32'd0, 8'd0);
    send_item(OP_INV_RANGE, 32'd0, 32'h0000_0100, 8'hFF);
    send_item(OP_STEP, 32'd0, 32'd0, 8'h01);
    finish_op();
    do_op(OP_INV_ALL, 32'd0, 32'd0);
    do_op(OP_CI_ALL, 32'd0, 32'd0);
    drain();

    set_regs(8'h00, 32'd1);
    run_phase();
    drain();
    set_regs(8'hFF, 32'hFFFF_FFFF);
    run_phase();
    drain();
    set_regs(8'($urandom_range(0, 255)), 32'd256);
    hold_go = 1'b1;
    run_phase();
    drain();
    set_regs(8'($urandom_range(0, 255)), CACHE_SIZE_RESET);
    run_phase();
    drain();
    set_regs(8'($urandom_range(0, 255)), $urandom_range(32, 4096));
    run_phase();
    drain();
    repeat (8) @(posedge clk);

    if (model.due_cmds.size() != 0) begin
      $display("%0t: %0d expected commands never arrived", $time, model.due_cmds.size());
      model.fails++;
    end
    if (model.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/crms_pkg.sv
rtl/crms_seq.sv
rtl/cache_range_maintenance_sequencer_unit.sv
rtl/crms_checker.sv
tb/tb_top.sv
